FILE: src/vertex_rotate_scale_transform_top_assert.svh
`ifndef VERTEX_ROTATE_SCALE_TRANSFORM_TOP_ASSERT_SVH
`define VERTEX_ROTATE_SCALE_TRANSFORM_TOP_ASSERT_SVH

// condition and consequence checked at the same clock edge
`define VRST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence checked in the clock cycle after the condition
`define VRST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vrst_pkg.sv
`default_nettype none

package vrst_pkg;

	localparam int COMPONENT_WIDTH = 32;
	localparam int CORDIC_STEPS = 16;

	localparam int CW = COMPONENT_WIDTH;
	localparam int KW = 32;               // scale factor, Q16.16
	localparam int PW = CW + KW;          // full product
	localparam int AW = 16;               // angle, Q2.13
	localparam int CS_W = 17;             // cos/sin, 15 fraction bits, 1.0 exact
	localparam int ZW = 34;               // CORDIC datapath
	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam int DW = 32;               // APB data
	localparam int ADDR_W = 4;
	localparam int IDX_W = ADDR_W - 2;

	localparam int RND_ROT = 15;
	localparam int RND_SCL = 16;
	localparam int CS_FRAC_SH = 15;

	localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_ANGLE = 2'd1;
	localparam logic [IDX_W-1:0] REG_SCALE = 2'd2;

	localparam logic [2:0] MODE_ZERO = 3'd0;
	localparam logic [2:0] MODE_ROT_X = 3'd1;
	localparam logic [2:0] MODE_ROT_Y = 3'd2;
	localparam logic [2:0] MODE_ROT_Z = 3'd3;
	localparam logic [2:0] MODE_SCALE = 3'd4;

	localparam logic signed [KW-1:0] SCALE_RESET = 32'sd65536;

	// angles at 29 fraction bits
	localparam logic signed [ZW-1:0] ANG_PI = 34'sd1686629713;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd843314857;
	localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ZW-1:0] RND_CS = 34'sd16384;

	localparam logic signed [CS_W-1:0] CS_MAX = 17'sd32768;
	localparam logic signed [CS_W-1:0] CS_MIN = -17'sd32768;

	localparam logic signed [PW:0] SAT_HI = (PW+1)'({(CW-1){1'b1}});
	localparam logic signed [PW:0] SAT_LO = ~SAT_HI;
	localparam logic signed [PW:0] HALF_ROT = (PW+1)'(1) <<< (RND_ROT - 1);
	localparam logic signed [PW:0] HALF_SCL = (PW+1)'(1) <<< (RND_SCL - 1);

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_LOAD,
		CS_RUN,
		CS_FIN
	} cordic_state_t;

	typedef struct packed {
		logic signed [CW-1:0] x_in;
		logic signed [CW-1:0] y_in;
		logic signed [CW-1:0] z_in;
		logic signed [CW-1:0] w_in;
	} vec_in_t;

	typedef struct packed {
		logic signed [CW-1:0] x_out;
		logic signed [CW-1:0] y_out;
		logic signed [CW-1:0] z_out;
		logic signed [CW-1:0] w_out;
	} vec_out_t;

	typedef struct packed {
		logic [2:0]             mode;
		logic signed [AW-1:0]   angle;
		logic signed [KW-1:0]   scale;
		logic                   angle_upd;
	} cfg_t;

	typedef struct packed {
		logic signed [CS_W-1:0] cos;
		logic signed [CS_W-1:0] sin;
	} trig_t;

	typedef struct packed {
		logic [2:0]           mode;
		logic signed [PW-1:0] m0;
		logic signed [PW-1:0] m1;
		logic signed [PW-1:0] m2;
		logic signed [PW-1:0] m3;
		vec_in_t              pass;
	} prod_t;

	// arctan(2^-i) at 29 fraction bits
	function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 34'sd421657428;
			5'd1: r = 34'sd248918915;
			5'd2: r = 34'sd131521918;
			5'd3: r = 34'sd66762579;
			5'd4: r = 34'sd33510843;
			5'd5: r = 34'sd16771758;
			5'd6: r = 34'sd8387925;
			5'd7: r = 34'sd4194219;
			5'd8: r = 34'sd2097141;
			5'd9: r = 34'sd1048575;
			5'd10: r = 34'sd524288;
			5'd11: r = 34'sd262144;
			5'd12: r = 34'sd131072;
			5'd13: r = 34'sd65536;
			5'd14: r = 34'sd32768;
			5'd15: r = 34'sd16384;
			5'd16: r = 34'sd8192;
			5'd17: r = 34'sd4096;
			5'd18: r = 34'sd2048;
			5'd19: r = 34'sd1024;
			5'd20: r = 34'sd512;
			5'd21: r = 34'sd256;
			5'd22: r = 34'sd128;
			5'd23: r = 34'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [CS_W-1:0] sat_cs(input logic signed [ZW-1:0] v);
		logic signed [CS_W-1:0] r;
		if (v > CS_MAX) begin
			r = CS_MAX;
		end else if (v < CS_MIN) begin
			r = CS_MIN;
		end else begin
			r = CS_W'(v);
		end
		return r;
	endfunction

	// round half up by dropping sh bits, then clamp to the component range
	function automatic logic signed [CW-1:0] round_sat(input logic signed [PW:0] v,
			input logic signed [PW:0] half, input int unsigned sh);
		logic signed [PW:0] t;
		logic signed [CW-1:0] r;
		t = (v + half) >>> sh;
		if (t > SAT_HI) begin
			r = CW'(SAT_HI);
		end else if (t < SAT_LO) begin
			r = CW'(SAT_LO);
		end else begin
			r = CW'(t);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/vrst_cfg.sv
`default_nettype none

module vrst_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vrst_pkg::ADDR_W-1:0] paddr,
	input  logic [vrst_pkg::DW-1:0]    pwdata,
	output logic [vrst_pkg::DW-1:0]    prdata,
	output logic                       pready,
	output vrst_pkg::cfg_t             cfg
);
	import vrst_pkg::*;

	logic [2:0]           mode_q;
	logic signed [AW-1:0] angle_q;
	logic signed [KW-1:0] scale_q;
	logic                 upd_q;
	logic                 wr;
	logic [IDX_W-1:0]     idx;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	assign idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ZERO;
			angle_q <= '0;
			scale_q <= SCALE_RESET;
			upd_q <= 1'b0;
		end else begin
			upd_q <= wr && (idx == REG_ANGLE);
			if (wr) begin
				case (idx)
					REG_MODE: mode_q <= pwdata[2:0];
					REG_ANGLE: angle_q <= pwdata[AW-1:0];
					REG_SCALE: scale_q <= pwdata[KW-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_MODE: prdata = DW'(mode_q);
			REG_ANGLE: prdata = DW'(angle_q);
			REG_SCALE: prdata = DW'(scale_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.mode = mode_q;
	assign cfg.angle = angle_q;
	assign cfg.scale = scale_q;
	assign cfg.angle_upd = upd_q;

endmodule

`default_nettype wire

FILE: src/vrst_cordic.sv
`default_nettype none
`include "vertex_rotate_scale_transform_top_assert.svh"

module vrst_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  vrst_pkg::cfg_t  cfg,
	output vrst_pkg::trig_t trig,
	output logic            busy
);
	import vrst_pkg::*;

	cordic_state_t        st_q, st_d;
	logic [STEP_W-1:0]    step_q;
	logic signed [ZW-1:0] x_q, y_q, z_q;
	logic                 flip_q;
	trig_t                trig_q;

	logic                 ld, it, fin;
	logic signed [ZW-1:0] z0, z_red, dx, dy, xr, yr, xf, yf;
	logic                 flip0;

	// an angle write restarts the run from any state
	always_comb begin
		st_d = st_q;
		case (st_q)
			CS_IDLE: if (cfg.angle_upd) st_d = CS_LOAD;
			CS_LOAD: st_d = CS_RUN;
			CS_RUN: if (step_q == STEP_W'(CORDIC_STEPS - 1)) st_d = CS_FIN;
			CS_FIN: st_d = CS_IDLE;
			default: st_d = CS_IDLE;
		endcase
		if (cfg.angle_upd) st_d = CS_LOAD;
	end

	always_comb begin
		ld = 1'b0;
		it = 1'b0;
		fin = 1'b0;
		busy = 1'b1;
		case (st_q)
			CS_IDLE: busy = 1'b0;
			CS_LOAD: ld = 1'b1;
			CS_RUN: it = 1'b1;
			CS_FIN: fin = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	// bring the angle into +-pi/2, remember to negate the result
	always_comb begin
		z0 = ZW'(cfg.angle) <<< 16;
		z_red = z0;
		flip0 = 1'b0;
		if (z0 > ANG_HALF_PI) begin
			z_red = z0 - ANG_PI;
			flip0 = 1'b1;
		end else if (z0 < -ANG_HALF_PI) begin
			z_red = z0 + ANG_PI;
			flip0 = 1'b1;
		end
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	assign xr = (x_q + RND_CS) >>> CS_FRAC_SH;
	assign yr = (y_q + RND_CS) >>> CS_FRAC_SH;
	assign xf = flip_q ? -xr : xr;
	assign yf = flip_q ? -yr : yr;

	// reset starts a run from the reset angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CS_LOAD;
			step_q <= '0;
		end else begin
			st_q <= st_d;
			if (ld) begin
				step_q <= '0;
			end else if (it) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z_red;
			flip_q <= flip0;
		end else if (it) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_step(5'(step_q));
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_step(5'(step_q));
			end
		end
		if (fin) begin
			trig_q.cos <= sat_cs(xf);
			trig_q.sin <= sat_cs(yf);
		end
	end

	assign trig = trig_q;

	`VRST_ASSERT_NEXT(a_upd_busy, clk, arst_n, cfg.angle_upd, busy,
		"angle update did not start a run")
	`VRST_ASSERT_NOW(a_trig_range, clk, arst_n, !busy,
		(trig_q.cos <= CS_MAX) && (trig_q.cos >= CS_MIN) &&
		(trig_q.sin <= CS_MAX) && (trig_q.sin >= CS_MIN),
		"sine or cosine out of range")
	`VRST_ASSERT_NOW(a_step_bound, clk, arst_n, st_q == CS_RUN,
		step_q < STEP_W'(CORDIC_STEPS), "iteration count overran")

endmodule

`default_nettype wire

FILE: src/vrst_prod.sv
`default_nettype none

module vrst_prod (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  vrst_pkg::vec_in_t item,
	input  vrst_pkg::cfg_t    cfg,
	input  vrst_pkg::trig_t   trig,
	output logic              valid_s2,
	output vrst_pkg::prod_t   prod_s2
);
	import vrst_pkg::*;

	logic                 valid_s1;
	vec_in_t              item_s1;
	logic [2:0]           mode_s1;

	logic signed [CW-1:0] a, b;
	logic signed [KW-1:0] k0, k1, k2, k3;
	logic signed [CW-1:0] o0, o1, o2, o3;
	prod_t                prod_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			mode_s1 <= cfg.mode;
		end
		prod_s2 <= prod_d;
	end

	// the two components that the rotation mixes
	always_comb begin
		case (mode_s1)
			MODE_ROT_X: begin
				a = item_s1.y_in;
				b = item_s1.z_in;
			end
			MODE_ROT_Y: begin
				a = item_s1.x_in;
				b = item_s1.z_in;
			end
			default: begin
				a = item_s1.x_in;
				b = item_s1.y_in;
			end
		endcase
	end

	always_comb begin
		if (mode_s1 == MODE_SCALE) begin
			k0 = cfg.scale;
			k1 = cfg.scale;
			k2 = cfg.scale;
			k3 = cfg.scale;
			o0 = item_s1.x_in;
			o1 = item_s1.y_in;
			o2 = item_s1.z_in;
			o3 = item_s1.w_in;
		end else begin
			k0 = KW'(trig.cos);
			k1 = KW'(trig.sin);
			k2 = KW'(trig.sin);
			k3 = KW'(trig.cos);
			o0 = a;
			o1 = b;
			o2 = a;
			o3 = b;
		end
	end

	always_comb begin
		prod_d.mode = mode_s1;
		prod_d.m0 = k0 * o0;
		prod_d.m1 = k1 * o1;
		prod_d.m2 = k2 * o2;
		prod_d.m3 = k3 * o3;
		prod_d.pass = item_s1;
	end

endmodule

`default_nettype wire

FILE: src/vrst_out.sv
`default_nettype none
`include "vertex_rotate_scale_transform_top_assert.svh"

module vrst_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	input  vrst_pkg::prod_t    prod_s2,
	output logic               done,
	output vrst_pkg::vec_out_t result
);
	import vrst_pkg::*;

	logic                 done_q;
	vec_out_t             result_q, result_d;
	logic signed [CW-1:0] rp, rq, s0, s1, s2;

	// rp = c*a + s*b, rq = c*b - s*a
	assign rp = round_sat((PW+1)'(prod_s2.m0) + (PW+1)'(prod_s2.m1), HALF_ROT, RND_ROT);
	assign rq = round_sat((PW+1)'(prod_s2.m3) - (PW+1)'(prod_s2.m2), HALF_ROT, RND_ROT);
	assign s0 = round_sat((PW+1)'(prod_s2.m0), HALF_SCL, RND_SCL);
	assign s1 = round_sat((PW+1)'(prod_s2.m1), HALF_SCL, RND_SCL);
	assign s2 = round_sat((PW+1)'(prod_s2.m2), HALF_SCL, RND_SCL);

	always_comb begin
		result_d = '0;
		case (prod_s2.mode)
			MODE_ROT_X: begin
				result_d.x_out = prod_s2.pass.x_in;
				result_d.y_out = rp;
				result_d.z_out = rq;
				result_d.w_out = prod_s2.pass.w_in;
			end
			MODE_ROT_Y: begin
				result_d.x_out = rp;
				result_d.y_out = prod_s2.pass.y_in;
				result_d.z_out = rq;
				result_d.w_out = prod_s2.pass.w_in;
			end
			MODE_ROT_Z: begin
				result_d.x_out = rp;
				result_d.y_out = rq;
				result_d.z_out = prod_s2.pass.z_in;
				result_d.w_out = prod_s2.pass.w_in;
			end
			MODE_SCALE: begin
				result_d.x_out = s0;
				result_d.y_out = s1;
				result_d.z_out = s2;
				result_d.w_out = prod_s2.pass.w_in;
			end
			default: result_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done = done_q;
	assign result = result_q;

	`VRST_ASSERT_NEXT(a_zero_matrix, clk, arst_n,
		valid_s2 && (prod_s2.mode == MODE_ZERO || prod_s2.mode > MODE_SCALE),
		result == '0, "zero matrix gave a nonzero word")
	`VRST_ASSERT_NEXT(a_w_pass, clk, arst_n,
		valid_s2 && (prod_s2.mode != MODE_ZERO) && (prod_s2.mode <= MODE_SCALE),
		result.w_out == $past(prod_s2.pass.w_in), "w not passed through")
	`VRST_ASSERT_NEXT(a_x_pass, clk, arst_n, valid_s2 && (prod_s2.mode == MODE_ROT_X),
		result.x_out == $past(prod_s2.pass.x_in), "x changed by rotation about X")

endmodule

`default_nettype wire

FILE: src/vertex_rotate_scale_transform_top.sv
`default_nettype none

// Homogeneous 4x4 rotate/scale transform: each word (x, y, z, w in Q16.16) is
// multiplied by the matrix the mode register selects and comes back as one
// result word. A word is taken at any edge where start is high and busy is low,
// one per clock, and its result shows on the result port for exactly one cycle
// with done high, once it has passed the input, product and result registers.
// There is no backpressure: the receiver must take every result the cycle it
// appears. Throughput is set by the product stage (four signed 32x32
// multipliers, fully pipelined), so words may follow each other with no gaps.
// busy is high after reset and after an angle write, while the shared CORDIC
// forms sine and cosine one iteration per clock; an angle write during a run
// restarts it. Write config only when no words are in flight.

module vertex_rotate_scale_transform_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vrst_pkg::ADDR_W-1:0] paddr,
	input  logic [vrst_pkg::DW-1:0]     pwdata,
	output logic [vrst_pkg::DW-1:0]     prdata,
	output logic                        pready,
	// input words
	input  logic                        start,
	output logic                        busy,
	input  vrst_pkg::vec_in_t           item,
	// result words
	output logic                        done,
	output vrst_pkg::vec_out_t          result
);
	import vrst_pkg::*;

	cfg_t    cfg;
	trig_t   trig;
	logic    cordic_busy;
	logic    accept;
	logic    valid_s2;
	prod_t   prod_s2;

	// register file; flags an angle write in the cycle after it
	vrst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sine/cosine of the angle, held until the run after the next angle write ends
	vrst_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.trig   (trig),
		.busy   (cordic_busy)
	);

	// hold off input from the angle write until the new coefficients land
	assign busy = cordic_busy | cfg.angle_upd;
	assign accept = start & ~busy;

	// input register (s1) and matrix products (s2)
	vrst_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg),
		.trig     (trig),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2)
	);

	// row sums, rounding, saturation and the result register
	vrst_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire
